// ===== rtl/pkq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkq_pkg
// shared item types, command codes and register indexes of the paced keycode
// queue
// ----------------------------------------------------------------------------
package pkq_pkg;

    localparam int KEY_W     = 16;
    localparam int REPS_W    = 7;
    localparam int TIME_W    = 32;
    localparam int PEND_W    = 7;
    localparam int CMD_W     = 3;
    localparam int GAP_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_MS       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_ENABLED = 8'd1;

    localparam logic [GAP_W-1:0] GAP_MS_RESET = 16'd10;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KEY_W-1:0]  key_in;
        logic [REPS_W-1:0] repeat_count;
        logic [TIME_W-1:0] now_ms;
    } cmd_item_t;

    typedef struct packed {
        logic              has_key;
        logic [KEY_W-1:0]  key_out;
        logic              last;
        logic [PEND_W-1:0] pending;
    } res_item_t;

    typedef struct packed {
        logic [GAP_W-1:0] gap_ms;
        logic             sink_enabled;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/pkq_ring_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkq_ring_ram
// ring storage of the queue: one write port, one read port with registered
// read data that holds its value until the next read
// ----------------------------------------------------------------------------
module pkq_ring_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pkq_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pkq_seq
// command sequencer: ring pointers, pacing state, push and pop walks over the
// ring ram and the result register
// ----------------------------------------------------------------------------
module pkq_seq #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pkq_pkg::cfg_t      cfg,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire pkq_pkg::cmd_item_t cmd_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output pkq_pkg::res_item_t      res_item
);

    import pkq_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PUSH  = 2'd1;
    localparam logic [1:0] ST_POP   = 2'd2;
    localparam logic [1:0] ST_QUERY = 2'd3;

    logic [1:0]         state_reg,     state_next;
    logic [PTR_W-1:0]   head_reg,      head_next;
    logic [PTR_W-1:0]   tail_reg,      tail_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [TIME_W-1:0]  last_send_reg, last_send_next;
    logic               has_sent_reg,  has_sent_next;
    logic [STORE_W-1:0] key_reg,       key_next;
    logic [REPS_W-1:0]  reps_reg,      reps_next;
    logic               flush_reg,     flush_next;
    logic               dv_reg,        dv_next;
    logic               pop_last_reg,  pop_last_next;
    logic [CNT_W-1:0]   pop_pend_reg,  pop_pend_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_item_reg,  res_item_next;

    logic               ram_we;
    logic               ram_re;
    logic [STORE_W-1:0] ram_rdata;
    logic               out_free;
    logic               full;
    logic               tick_go;
    logic               issue;
    logic               load;
    res_item_t          load_item;
    logic [TIME_W-1:0]  elapsed;
    logic [CNT_W-1:0]   count_dec;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    pkq_ring_ram #(
        .DEPTH (DEPTH),
        .WIDTH (STORE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign out_free  = !res_valid_reg || res_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign elapsed   = cmd_item.now_ms - last_send_reg;
    // wrap-safe pacing check
    assign tick_go   = (count_reg != '0) &&
                       (!has_sent_reg || (elapsed >= TIME_W'(cfg.gap_ms)));
    assign count_dec = count_reg - 1'b1;
    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        last_send_next = last_send_reg;
        has_sent_next  = has_sent_reg;
        key_next       = key_reg;
        reps_next      = reps_reg;
        flush_next     = flush_reg;
        dv_next        = dv_reg;
        pop_last_next  = pop_last_reg;
        pop_pend_next  = pop_pend_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_item_next  = res_item_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        issue          = 1'b0;
        load           = 1'b0;
        load_item      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_item.command)
                        CMD_CLEAR:
                        begin
                            head_next     = '0;
                            tail_next     = '0;
                            count_next    = '0;
                            has_sent_next = 1'b0;
                        end
                        CMD_PUSH:
                        begin
                            key_next   = cmd_item.key_in[STORE_W-1:0];
                            reps_next  = cmd_item.repeat_count;
                            state_next = ST_PUSH;
                        end
                        CMD_TICK:
                        begin
                            if (tick_go)
                            begin
                                last_send_next = cmd_item.now_ms;
                                has_sent_next  = 1'b1;
                                flush_next     = 1'b0;
                                issue          = 1'b1;
                                state_next     = ST_POP;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            flush_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                issue      = 1'b1;
                                state_next = ST_POP;
                            end
                            else
                            begin
                                has_sent_next = 1'b0;
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_next = ST_QUERY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PUSH:
            begin
                // one copy per cycle, extra copies dropped once full
                if ((reps_reg != '0) && !full)
                begin
                    ram_we     = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                    reps_next  = reps_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                // read data holds while the result register is busy
                if (dv_reg && (!cfg.sink_enabled || out_free))
                begin
                    if (cfg.sink_enabled)
                    begin
                        load              = 1'b1;
                        load_item.has_key = 1'b1;
                        load_item.key_out = KEY_W'(ram_rdata);
                        load_item.last    = pop_last_reg;
                        load_item.pending = PEND_W'(pop_pend_reg);
                    end
                    if (flush_reg && (count_reg != '0))
                    begin
                        issue = 1'b1;
                    end
                    else
                    begin
                        dv_next    = 1'b0;
                        state_next = ST_IDLE;
                        if (flush_reg)
                        begin
                            has_sent_next = 1'b0;
                        end
                    end
                end
            end
            ST_QUERY:
            begin
                if (out_free)
                begin
                    load              = 1'b1;
                    load_item.has_key = 1'b0;
                    load_item.key_out = '0;
                    load_item.last    = 1'b1;
                    load_item.pending = PEND_W'(count_reg);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (issue)
        begin
            ram_re        = 1'b1;
            head_next     = ptr_inc(head_reg);
            count_next    = count_dec;
            pop_pend_next = count_dec;
            pop_last_next = !flush_next || (count_dec == '0);
            dv_next       = 1'b1;
        end

        if (load)
        begin
            res_valid_next = 1'b1;
            res_item_next  = load_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            last_send_reg <= '0;
            has_sent_reg  <= 1'b0;
            flush_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            last_send_reg <= last_send_next;
            has_sent_reg  <= has_sent_next;
            flush_reg     <= flush_next;
            dv_reg        <= dv_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        reps_reg     <= reps_next;
        pop_last_reg <= pop_last_next;
        pop_pend_reg <= pop_pend_next;
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == '0) || (count_reg == CNT_W'(DEPTH))) |-> (head_reg == tail_reg))
        else $error("head and tail disagree with count");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ring read and write in the same cycle");

    a_dv_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (state_reg == ST_POP))
        else $error("read data pending outside pop walk");

    a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PUSH) && (reps_reg != '0) && !full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push copy not counted");
`endif

endmodule
`default_nettype wire

// ===== rtl/paced_keycode_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// paced_keycode_queue_top
// ring queue of keycodes with time-paced single sends, flush and query
// ----------------------------------------------------------------------------
// One item is worked on at a time; cmd_ready is high whenever the sequencer is
// idle, even while a result still waits in the output register. A push makes
// one ring write per cycle, stopping early when the ring is full. A flush
// sends one entry per cycle when the consumer keeps res_ready high, through
// the single read port of the ring ram, with read data registered. The ring
// needs no clearing after reset: an entry is only read after a push wrote it.
// Configuration writes are always accepted and are meant to be made only while
// the block is idle.
// ----------------------------------------------------------------------------
module paced_keycode_queue_top #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire pkq_pkg::cmd_item_t              cmd_item,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output pkq_pkg::res_item_t                   res_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pkq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pkq_pkg::CFG_DAT_W-1:0]   cfg_data
);

    import pkq_pkg::*;

    logic [GAP_W-1:0] gap_ms_reg;
    logic             sink_enabled_reg;
    cfg_t             cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ms_reg       <= GAP_MS_RESET;
            sink_enabled_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAP_MS:       gap_ms_reg       <= cfg_data[GAP_W-1:0];
                REG_SINK_ENABLED: sink_enabled_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.gap_ms       = gap_ms_reg;
    assign cfg.sink_enabled = sink_enabled_reg;

    pkq_seq #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule
`default_nettype wire

// ===== tb/paced_keycode_queue_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paced_keycode_queue_top_tb
// self-checking bench for the paced keycode queue: directed corner cases, then
// random command traffic under three idling mixes, every result checked
// against a cycle-free copy of the queue state
// ----------------------------------------------------------------------------
module paced_keycode_queue_top_tb;

    import pkq_pkg::*;

    localparam int QDEPTH = 64;
    localparam int PTR_W  = $clog2(QDEPTH);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    cmd_item_t            cmd_item  = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    res_item_t            res_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // shadow copy of the queue and its registers
    logic [KEY_W-1:0]  ring_copy [QDEPTH];
    logic [PTR_W-1:0]  head_ptr;
    logic [PEND_W-1:0] fill;
    logic [TIME_W-1:0] last_send_ms;
    logic              sent_since_clear;
    logic [GAP_W-1:0]  gap_cfg;
    logic              sink_cfg;

    res_item_t expected_sends [$];

    int send_idle_pct  = 34;
    int recv_stall_pct = 84;
    int fail_count     = 0;
    int cmds_sent      = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    logic [TIME_W-1:0] sim_ms;

    paced_keycode_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic cmd_item_t mk_cmd(input logic [CMD_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input logic [REPS_W-1:0] reps,
                                         input logic [TIME_W-1:0] now);
        cmd_item_t it;
        it.command      = op;
        it.key_in       = key;
        it.repeat_count = reps;
        it.now_ms       = now;
        return it;
    endfunction

    // pop the oldest entry and queue its result if the sink is on
    task automatic dequeue_one(input logic fin_when_empty);
        res_item_t r;
        r.key_out = ring_copy[head_ptr];
        head_ptr  = head_ptr + 1'b1;
        fill      = fill - 1'b1;
        r.has_key = 1'b1;
        r.last    = fin_when_empty ? (fill == 0) : 1'b1;
        r.pending = fill;
        if (sink_cfg)
            expected_sends.push_back(r);
    endtask

    task automatic queue_model_step(input cmd_item_t it);
        logic [TIME_W-1:0] elapsed;
        res_item_t         r;
        case (it.command)
            CMD_CLEAR:
            begin
                head_ptr         = '0;
                fill             = '0;
                sent_since_clear = 1'b0;
            end
            CMD_PUSH:
            begin
                for (int i = 0; i < it.repeat_count && fill < QDEPTH; i++)
                begin
                    ring_copy[head_ptr + fill[PTR_W-1:0]] = it.key_in;
                    fill = fill + 1'b1;
                end
            end
            CMD_TICK:
            begin
                elapsed = it.now_ms - last_send_ms;
                if (fill != 0 && !(sent_since_clear && elapsed < TIME_W'(gap_cfg)))
                begin
                    last_send_ms     = it.now_ms;
                    sent_since_clear = 1'b1;
                    dequeue_one(1'b0);
                end
            end
            CMD_FLUSH:
            begin
                while (fill != 0)
                    dequeue_one(1'b1);
                sent_since_clear = 1'b0;
            end
            CMD_QUERY:
            begin
                r.has_key = 1'b0;
                r.key_out = '0;
                r.last    = 1'b1;
                r.pending = fill;
                expected_sends.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_cmd(input cmd_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        cmd_item  <= it;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        queue_model_step(it);
        cmds_sent++;
    endtask

    // no result owed; allow the longest push or silent flush to finish
    task automatic wait_queue_idle();
        cmd_valid <= 1'b0;
        while (expected_sends.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic program_regs(input logic [GAP_W-1:0] gap,
                                input logic [CFG_DAT_W-1:0] sink_word,
                                input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx_list [$];
        logic [CFG_DAT_W-1:0] dat_list [$];
        wait_queue_idle();
        if (poke_unused)
        begin
            idx_list.push_back(REG_SINK_ENABLED + 1'b1);
            dat_list.push_back(CFG_DAT_W'($urandom));
            idx_list.push_back('1);
            dat_list.push_back('1);
        end
        idx_list.push_back(REG_GAP_MS);
        dat_list.push_back(gap);
        idx_list.push_back(REG_SINK_ENABLED);
        dat_list.push_back(sink_word);
        for (int w = 0; w < idx_list.size(); w++)
        begin
            cfg_index <= idx_list[w];
            cfg_data  <= dat_list[w];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            if (idx_list[w] == REG_GAP_MS)
                gap_cfg = dat_list[w];
            else if (idx_list[w] == REG_SINK_ENABLED)
                sink_cfg = dat_list[w][0];
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- checker
    always @(posedge clk)
    begin : check_results
        res_item_t want;
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (expected_sends.size() == 0)
            begin
                $error("unexpected result: has_key %0d key_out %h pending %0d",
                       res_item.has_key, res_item.key_out, res_item.pending);
                fail_count++;
            end
            else
            begin
                want = expected_sends.pop_front();
                if (res_item.has_key !== want.has_key)
                begin
                    $error("has_key: expected %0d, got %0d", want.has_key, res_item.has_key);
                    fail_count++;
                end
                if (res_item.key_out !== want.key_out)
                begin
                    $error("key_out: expected %h, got %h", want.key_out, res_item.key_out);
                    fail_count++;
                end
                if (res_item.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, res_item.last);
                    fail_count++;
                end
                if (res_item.pending !== want.pending)
                begin
                    $error("pending: expected %0d, got %0d", want.pending, res_item.pending);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_empty_queue();
        send_cmd(mk_cmd(CMD_QUERY, '0, '0, '0));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd1000));
        send_cmd(mk_cmd(CMD_FLUSH, '0, '0, '0));
    endtask

    task automatic test_push_overflow();
        send_cmd(mk_cmd(CMD_PUSH, 16'hFFFF, 7'd0, '0));
        send_cmd(mk_cmd(CMD_PUSH, 16'h0000, 7'd1, '0));
        // all ones repeat count: ring fills and the rest is dropped
        send_cmd(mk_cmd(CMD_PUSH, 16'hA5A5, 7'h7F, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(CMD_QUERY, '0, '0, '0));
    endtask

    task automatic test_flush_full();
        send_cmd(mk_cmd(CMD_FLUSH, '0, '0, '0));
    endtask

    task automatic test_tick_pacing();
        send_cmd(mk_cmd(CMD_PUSH, 16'h1111, 7'd2, '0));
        send_cmd(mk_cmd(CMD_PUSH, 16'h2222, 7'd1, '0));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'hFFFF_FFFA));
        // elapsed wraps to 8, below the reset gap of 10
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd2));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd4));
        send_cmd(mk_cmd(CMD_CLEAR, '0, '0, '0));
        send_cmd(mk_cmd(CMD_PUSH, 16'h00FF, 7'd1, '0));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd5));
    endtask

    task automatic test_unused_codes();
        send_cmd(mk_cmd(CMD_PUSH, 16'h7777, 7'd1, '0));
        for (int op = CMD_QUERY + 1; op < (1 << CMD_W); op++)
            send_cmd(mk_cmd(CMD_W'(op), KEY_W'($urandom), REPS_W'($urandom), $urandom));
        send_cmd(mk_cmd(CMD_QUERY, '0, '0, '0));
    endtask

    task automatic test_sink_and_gap_extremes();
        // sink word with bit 0 low and every other bit high
        program_regs('0, 16'hFFFE, 1'b1);
        send_cmd(mk_cmd(CMD_PUSH, 16'h3C3C, 7'd3, '0));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd50));
        send_cmd(mk_cmd(CMD_FLUSH, '0, '0, '0));
        send_cmd(mk_cmd(CMD_QUERY, '0, '0, '0));
        program_regs('1, 16'h0001, 1'b0);
        send_cmd(mk_cmd(CMD_PUSH, 16'h5A5A, 7'd2, '0));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd100));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd100 + 32'hFFFE));
        send_cmd(mk_cmd(CMD_TICK, '0, '0, 32'd100 + 32'hFFFF));
    endtask

    // mostly realistic traffic: forward-moving time, short pushes, steady ticks
    task automatic test_random_traffic(input int n_items, input logic [TIME_W-1:0] start_ms);
        int        pick;
        cmd_item_t it;
        sim_ms = start_ms;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            it   = mk_cmd(CMD_TICK, KEY_W'($urandom), '0, sim_ms);
            if (pick < 35)
            begin
                it.command      = CMD_PUSH;
                it.repeat_count = ($urandom_range(0, 99) < 85) ?
                                  REPS_W'($urandom_range(1, 4)) : REPS_W'($urandom);
            end
            else if (pick < 70)
            begin
                sim_ms    = sim_ms + $urandom_range(0, 2 * gap_cfg + 2);
                it.now_ms = sim_ms;
            end
            else if (pick < 78)
                it.command = CMD_QUERY;
            else if (pick < 85)
                it.command = CMD_FLUSH;
            else if (pick < 90)
                it.command = CMD_CLEAR;
            else if (pick < 93)
            begin
                it.command      = CMD_W'($urandom_range(CMD_QUERY + 1, (1 << CMD_W) - 1));
                it.repeat_count = REPS_W'($urandom);
                it.now_ms       = $urandom;
            end
            else
                it.now_ms = $urandom;
            send_cmd(it);
        end
    endtask

    initial
    begin
        head_ptr         = '0;
        fill             = '0;
        last_send_ms     = '0;
        sent_since_clear = 1'b0;
        gap_cfg          = GAP_MS_RESET;
        sink_cfg         = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_push_overflow();
        test_flush_full();
        test_tick_pacing();
        test_unused_codes();
        test_sink_and_gap_extremes();

        program_regs(GAP_W'($urandom_range(1, 12)), 16'h0001, 1'b0);
        test_random_traffic(40, $urandom);

        send_idle_pct  = 84;
        recv_stall_pct = 34;
        program_regs(GAP_W'($urandom_range(0, 25)), 16'h0001, 1'b0);
        // start just below the wrap point of the millisecond counter
        test_random_traffic(40, 32'hFFFF_FFC0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_regs(GAP_W'(5), 16'h0001, 1'b0);
        test_random_traffic(40, $urandom);

        wait_queue_idle();
        $display("run covered %0d commands, %0d results and %0d register writes",
                 cmds_sent, results_seen, reg_writes);
        $display("directed corners, then random traffic under three idle/stall mixes");
        if (fail_count == 0 && expected_sends.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
